/* design/mpqdk_pkg.sv */
// ----------------------------------------------------------------------------
// mpqdk_pkg
// Shared types and constants for the unsorted-list minimum priority queue.
// ----------------------------------------------------------------------------
package mpqdk_pkg;

  // Field widths of the channels
  localparam int ACTION_W = 3;
  localparam int KEY_W    = 16;
  localparam int PRI_W    = 16;
  localparam int STATUS_W = 2;

  // Defaults for the top-level parameters
  localparam int CAPACITY_DEF      = 64;
  localparam int KEY_BITS_DEF      = 16;
  localparam int PRIORITY_BITS_DEF = 16;

  // Request actions; codes five to seven are no-ops
  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT   = 3'd0,
    ACT_FIND_MIN = 3'd1,
    ACT_CHANGE   = 3'd2,
    ACT_CONTAINS = 3'd3,
    ACT_REMOVE   = 3'd4
  } action_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // One finished result, handed from the controller to the output stage
  typedef struct packed {
    logic [KEY_W-1:0] result_key;
    logic             found;
    status_t          status;
    logic             is_empty;
  } mpqdk_res_t;

endpackage

/* design/mpqdk_chan_if.sv */
// ----------------------------------------------------------------------------
// mpqdk_chan_if
// Valid/ready channels for requests and results of the priority queue.
// ----------------------------------------------------------------------------

// Request channel
interface mpqdk_in_if
  import mpqdk_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [KEY_W-1:0]    key;
  logic [PRI_W-1:0]    priority_req;

  modport source (output valid, output action, output key, output priority_req,
                  input ready);
  modport sink   (input valid, input action, input key, input priority_req,
                  output ready);
endinterface

// Result channel
interface mpqdk_out_if
  import mpqdk_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [KEY_W-1:0]    result_key;
  logic                found;
  logic [STATUS_W-1:0] status;
  logic                is_empty;

  modport source (output valid, output result_key, output found, output status,
                  output is_empty, input ready);
  modport sink   (input valid, input result_key, input found, input status,
                  input is_empty, output ready);
endinterface

/* design/mpqdk_mem.sv */
// ----------------------------------------------------------------------------
// mpqdk_mem
// Entry store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mpqdk_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write the entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/mpqdk_ctrl.sv */
// ----------------------------------------------------------------------------
// mpqdk_ctrl
// Sequencer: appends entries, scans the store for the minimum or a key,
// patches a priority and shifts entries down to close the gap on removal.
// ----------------------------------------------------------------------------
module mpqdk_ctrl
  import mpqdk_pkg::*;
#(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int KEY_BITS      = KEY_BITS_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
  parameter int AW            = $clog2(CAPACITY),
  parameter int WIDTH         = KEY_BITS + PRIORITY_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  mpqdk_in_if.sink         in_chan,
  output logic             res_valid,
  input  logic             res_ready,
  output mpqdk_res_t       res,
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output logic [WIDTH-1:0] mem_wdata,
  output logic             mem_re,
  output logic [AW-1:0]    mem_raddr,
  input  logic [WIDTH-1:0] mem_rdata
);

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int KIN = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int PIN = (PRIORITY_BITS < PRI_W) ? PRIORITY_BITS : PRI_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_EVAL  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                          state_r, state_nxt;
  action_t                         act_r, act_nxt;
  logic [KEY_BITS-1:0]             key_r, key_nxt;
  logic signed [PRIORITY_BITS-1:0] pri_r, pri_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic [AW-1:0]                   rd_idx_r, rd_idx_nxt;
  logic                            issuing_r, issuing_nxt;
  logic                            pend_r, pend_nxt;
  logic [AW-1:0]                   pend_idx_r, pend_idx_nxt;
  logic signed [PRIORITY_BITS-1:0] best_pri_r, best_pri_nxt;
  logic [KEY_BITS-1:0]             best_key_r, best_key_nxt;
  logic [AW-1:0]                   best_idx_r, best_idx_nxt;
  logic                            hit_r, hit_nxt;
  logic [KEY_W-1:0]                res_key_r, res_key_nxt;
  logic                            res_found_r, res_found_nxt;
  status_t                         res_status_r, res_status_nxt;

  logic [KEY_BITS-1:0]             in_key_ext;
  logic signed [PRIORITY_BITS-1:0] in_pri_ext;
  logic [KEY_BITS+KIN-1:0]         key_wide;
  logic [PRIORITY_BITS+PIN-1:0]    pri_wide;
  logic [KEY_BITS+KEY_W-1:0]       best_key_wide;
  logic [CW-1:0]                   count_m1;
  logic [AW-1:0]                   last_idx;
  logic                            full;
  logic                            none;
  logic [KEY_BITS-1:0]             rd_key;
  logic signed [PRIORITY_BITS-1:0] rd_pri;
  logic                            scan_min;

  // Reduce the request fields to the stored widths
  assign key_wide   = {{KEY_BITS{1'b0}}, in_chan.key[KIN-1:0]};
  assign in_key_ext = key_wide[KEY_BITS-1:0];
  assign pri_wide   = {{PRIORITY_BITS{in_chan.priority_req[PIN-1]}},
                       in_chan.priority_req[PIN-1:0]};
  assign in_pri_ext = signed'(pri_wide[PRIORITY_BITS-1:0]);

  // Stored key as a result field
  assign best_key_wide = {{KEY_W{1'b0}}, best_key_r};

  assign count_m1 = count_r - CW'(1);
  assign last_idx = count_m1[AW-1:0];
  assign full     = (count_r == CW'(CAPACITY));
  assign none     = (count_r == '0);
  assign rd_key   = mem_rdata[WIDTH-1:PRIORITY_BITS];
  assign rd_pri   = signed'(mem_rdata[PRIORITY_BITS-1:0]);
  assign scan_min = (act_r == ACT_FIND_MIN) || (act_r == ACT_REMOVE);

  assign in_chan.ready = (state_r == S_IDLE);
  assign res_valid     = (state_r == S_DONE);
  assign res.result_key = res_key_r;
  assign res.found      = res_found_r;
  assign res.status     = res_status_r;
  assign res.is_empty   = none;

  // Sequence one request
  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    key_nxt        = key_r;
    pri_nxt        = pri_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    issuing_nxt    = issuing_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    best_pri_nxt   = best_pri_r;
    best_key_nxt   = best_key_r;
    best_idx_nxt   = best_idx_r;
    hit_nxt        = hit_r;
    res_key_nxt    = res_key_r;
    res_found_nxt  = res_found_r;
    res_status_nxt = res_status_r;
    mem_we         = 1'b0;
    mem_waddr      = count_r[AW-1:0];
    mem_wdata      = {in_key_ext, in_pri_ext};
    mem_re         = 1'b0;
    mem_raddr      = rd_idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          act_nxt        = action_t'(in_chan.action);
          key_nxt        = in_key_ext;
          pri_nxt        = in_pri_ext;
          res_key_nxt    = '0;
          res_found_nxt  = 1'b0;
          res_status_nxt = ST_OK;
          rd_idx_nxt     = '0;
          issuing_nxt    = 1'b1;
          hit_nxt        = 1'b0;
          state_nxt      = S_DONE;
          unique case (action_t'(in_chan.action))
            ACT_INSERT: begin
              // Append at the tail, or flag full
              if (full) begin
                res_status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            ACT_FIND_MIN, ACT_CHANGE, ACT_CONTAINS, ACT_REMOVE: begin
              if (none) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue one read per cycle up to the last entry
        if (issuing_r) begin
          mem_re       = 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = rd_idx_r;
          if (rd_idx_r == last_idx) begin
            issuing_nxt = 1'b0;
          end else begin
            rd_idx_nxt = rd_idx_r + AW'(1);
          end
        end
        // Fold the returning entry into the running minimum or first match
        if (pend_r) begin
          if (scan_min) begin
            if (pend_idx_r == '0 || rd_pri < best_pri_r) begin
              best_pri_nxt = rd_pri;
              best_key_nxt = rd_key;
              best_idx_nxt = pend_idx_r;
            end
          end else if (!hit_r && rd_key == key_r) begin
            hit_nxt      = 1'b1;
            best_idx_nxt = pend_idx_r;
          end
          if (pend_idx_r == last_idx) begin
            state_nxt = S_EVAL;
          end
        end
      end

      S_EVAL: begin
        state_nxt = S_DONE;
        priority case (act_r)
          ACT_FIND_MIN: begin
            res_key_nxt = best_key_wide[KEY_W-1:0];
          end
          ACT_CONTAINS: begin
            res_found_nxt = hit_r;
          end
          ACT_CHANGE: begin
            // Patch the priority of the first match
            res_found_nxt = hit_r;
            mem_we        = hit_r;
            mem_waddr     = best_idx_r;
            mem_wdata     = {key_r, pri_r};
          end
          default: begin
            // Remove: close the gap unless the minimum is the tail
            res_key_nxt = best_key_wide[KEY_W-1:0];
            if (best_idx_r == last_idx) begin
              count_nxt = count_m1;
            end else begin
              rd_idx_nxt  = best_idx_r + AW'(1);
              issuing_nxt = 1'b1;
              state_nxt   = S_SHIFT;
            end
          end
        endcase
      end

      S_SHIFT: begin
        // Read entry i+1 and write it back at i in the following cycle
        if (issuing_r) begin
          mem_re       = 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = rd_idx_r;
          if (rd_idx_r == last_idx) begin
            issuing_nxt = 1'b0;
          end else begin
            rd_idx_nxt = rd_idx_r + AW'(1);
          end
        end
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pend_idx_r - AW'(1);
          mem_wdata = mem_rdata;
          if (pend_idx_r == last_idx) begin
            count_nxt = count_m1;
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        // Hold the result until the output stage takes it
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      issuing_r <= 1'b0;
      pend_r    <= 1'b0;
      hit_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      issuing_r <= issuing_nxt;
      pend_r    <= pend_nxt;
      hit_r     <= hit_nxt;
    end
  end

  // Payload and scan registers
  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    key_r        <= key_nxt;
    pri_r        <= pri_nxt;
    rd_idx_r     <= rd_idx_nxt;
    pend_idx_r   <= pend_idx_nxt;
    best_pri_r   <= best_pri_nxt;
    best_key_r   <= best_key_nxt;
    best_idx_r   <= best_idx_nxt;
    res_key_r    <= res_key_nxt;
    res_found_r  <= res_found_nxt;
    res_status_r <= res_status_nxt;
  end

endmodule

/* design/min_priority_queue_decrease_key.sv */
// Flow: insert, no-op codes and requests on an empty queue skip the scan and
//   go straight to the result; find_min, change_priority and contains scan all
//   stored entries, and remove_min also shifts the entries behind the minimum.
// Throughput: one request at a time; the single read port of the entry store
//   reads one entry per cycle, which sets the scan and shift length.
// Reset: synchronous, active low; empties the queue, entry store is not cleared.
// ----------------------------------------------------------------------------
// min_priority_queue_decrease_key
// Minimum priority queue over an unsorted entry list with priority update.
// ----------------------------------------------------------------------------
module min_priority_queue_decrease_key
  import mpqdk_pkg::*;
#(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int KEY_BITS      = KEY_BITS_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mpqdk_in_if.sink   in_chan,
  mpqdk_out_if.source out_chan
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int WIDTH = KEY_BITS + PRIORITY_BITS;

  logic             res_valid;
  logic             res_ready;
  mpqdk_res_t       res;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [WIDTH-1:0] mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [WIDTH-1:0] mem_rdata;

  logic             out_valid_r;
  mpqdk_res_t       out_res_r;

  mpqdk_ctrl #(
    .CAPACITY      (CAPACITY),
    .KEY_BITS      (KEY_BITS),
    .PRIORITY_BITS (PRIORITY_BITS),
    .AW            (AW),
    .WIDTH         (WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  mpqdk_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (WIDTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: take a new result when empty or being drained
  assign res_ready = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.result_key = out_res_r.result_key;
  assign out_chan.found      = out_res_r.found;
  assign out_chan.status     = out_res_r.status;
  assign out_chan.is_empty   = out_res_r.is_empty;

endmodule

/* verif/min_priority_queue_decrease_key_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_priority_queue_decrease_key_tb
// Self-checking bench for the unsorted-list minimum priority queue. A short
// table of requests covers the empty and tie cases and duplicate keys. Random
// fill, drain, update and mixed phases follow. Typed table rows are compared
// with their table result, all other results with a local queue predictor, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module min_priority_queue_decrease_key_tb;
  import mpqdk_pkg::*;

  localparam int CAPACITY     = CAPACITY_DEF;
  localparam int MAX_GAP      = 18;
  localparam int RANDOM_ITEMS = 1880;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;
  localparam int STALL_LIMIT  = 4000;
  localparam int SHOW_LIMIT   = 10;

  // Action codes with no operation behind them
  localparam logic [ACTION_W-1:0] ACT_SPARE_LO  = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_MID = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_HI  = 3'd7;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_UPDATE} phase_t;

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic [KEY_W-1:0]    key;
    logic [PRI_W-1:0]    pri;
    logic                typed;
    mpqdk_res_t          res;
  } stim_row_t;

  // Results that can be read off directly
  localparam mpqdk_res_t RES_EMPTY_Q = '{16'h0000, 1'b0, ST_EMPTY, 1'b1};
  localparam mpqdk_res_t RES_IDLE    = '{16'h0000, 1'b0, ST_OK, 1'b1};
  localparam mpqdk_res_t RES_OK      = '{16'h0000, 1'b0, ST_OK, 1'b0};
  localparam mpqdk_res_t RES_HIT     = '{16'h0000, 1'b1, ST_OK, 1'b0};
  localparam mpqdk_res_t RES_MIN1234 = '{16'h1234, 1'b0, ST_OK, 1'b0};

  // Directed requests; rows with typed low are checked against the predictor
  localparam stim_row_t DIRECTED_ROWS [0:22] = '{
    '{ACT_FIND_MIN,  16'h0000, 16'h0000, 1'b1, RES_EMPTY_Q},
    '{ACT_CHANGE,    16'h0000, 16'h0000, 1'b1, RES_EMPTY_Q},
    '{ACT_CONTAINS,  16'hffff, 16'h7fff, 1'b1, RES_EMPTY_Q},
    '{ACT_REMOVE,    16'h0000, 16'h0000, 1'b1, RES_EMPTY_Q},
    '{ACT_SPARE_LO,  16'h0000, 16'h0000, 1'b1, RES_IDLE},
    '{ACT_SPARE_HI,  16'hffff, 16'h8000, 1'b1, RES_IDLE},
    '{ACT_INSERT,    16'hffff, 16'h7fff, 1'b1, RES_OK},
    '{ACT_INSERT,    16'h0000, 16'h8000, 1'b1, RES_OK},
    '{ACT_INSERT,    16'h1234, 16'h8000, 1'b1, RES_OK},
    '{ACT_FIND_MIN,  16'h0000, 16'h0000, 1'b1, RES_OK},
    '{ACT_INSERT,    16'h0000, 16'h0001, 1'b1, RES_OK},
    '{ACT_CHANGE,    16'h0000, 16'h7fff, 1'b1, RES_HIT},
    '{ACT_FIND_MIN,  16'h0000, 16'h0000, 1'b1, RES_MIN1234},
    '{ACT_CONTAINS,  16'hffff, 16'h0000, 1'b1, RES_HIT},
    '{ACT_CONTAINS,  16'h5555, 16'h0000, 1'b1, RES_OK},
    '{ACT_CHANGE,    16'h5555, 16'h8000, 1'b1, RES_OK},
    '{ACT_CHANGE,    16'hffff, 16'h8000, 1'b1, RES_HIT},
    '{ACT_REMOVE,    16'h0000, 16'h0000, 1'b0, RES_OK},
    '{ACT_REMOVE,    16'h0000, 16'h0000, 1'b0, RES_OK},
    '{ACT_SPARE_MID, 16'h0000, 16'h0000, 1'b1, RES_OK},
    '{ACT_REMOVE,    16'h0000, 16'h0000, 1'b0, RES_OK},
    '{ACT_REMOVE,    16'h0000, 16'h0000, 1'b0, RES_OK},
    '{ACT_CONTAINS,  16'h0000, 16'h0000, 1'b1, RES_EMPTY_Q}
  };

  logic clk = 1'b0;
  logic rst_n;

  mpqdk_in_if  in_chan_if ();
  mpqdk_out_if out_chan_if ();

  min_priority_queue_decrease_key dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan_if),
    .out_chan (out_chan_if)
  );

  // Predicted queue contents, in insertion order
  logic [KEY_W-1:0]        pq_keys [CAPACITY];
  logic signed [PRI_W-1:0] pq_pris [CAPACITY];
  int                      pq_count = 0;

  mpqdk_res_t expected_q [$];
  int         mismatches   = 0;
  int         idle_cycles  = 0;
  logic       hold_off_req = 1'b0;
  logic       steady       = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Smallest priority; the earliest entry wins a tie
  function automatic int min_slot();
    int best;
    best = 0;
    for (int i = 1; i < pq_count; i++) begin
      if (pq_pris[i] < pq_pris[best]) best = i;
    end
    return best;
  endfunction

  // First entry holding the key, or -1
  function automatic int key_slot(logic [KEY_W-1:0] key);
    for (int i = 0; i < pq_count; i++) begin
      if (pq_keys[i] == key) return i;
    end
    return -1;
  endfunction

  // Apply one request to the predicted queue and return its result
  function automatic mpqdk_res_t queue_step(logic [ACTION_W-1:0] act,
                                            logic [KEY_W-1:0] key,
                                            logic signed [PRI_W-1:0] pri);
    mpqdk_res_t res;
    int         slot;
    res = '0;
    res.status = ST_OK;
    if (pq_count == 0 && act inside {ACT_FIND_MIN, ACT_CHANGE, ACT_CONTAINS, ACT_REMOVE}) begin
      res.status = ST_EMPTY;
    end else begin
      case (act)
        ACT_INSERT: begin
          if (pq_count >= CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            pq_keys[pq_count] = key;
            pq_pris[pq_count] = pri;
            pq_count++;
          end
        end
        ACT_FIND_MIN: begin
          res.result_key = pq_keys[min_slot()];
        end
        ACT_CHANGE: begin
          slot = key_slot(key);
          if (slot >= 0) begin
            pq_pris[slot] = pri;
            res.found = 1'b1;
          end
        end
        ACT_CONTAINS: begin
          res.found = (key_slot(key) >= 0);
        end
        ACT_REMOVE: begin
          slot = min_slot();
          res.result_key = pq_keys[slot];
          // Close the gap, keeping the order of the rest
          for (int i = slot; i + 1 < pq_count; i++) begin
            pq_keys[i] = pq_keys[i + 1];
            pq_pris[i] = pq_pris[i + 1];
          end
          pq_count--;
        end
        default: ;
      endcase
    end
    res.is_empty = (pq_count == 0);
    return res;
  endfunction

  // Half the time a key already stored, so that searches hit; extremes now and then
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return KEY_W'($urandom);
      default: begin
        if (pq_count > 0) return pq_keys[$urandom_range(0, pq_count - 1)];
        return KEY_W'($urandom);
      end
    endcase
  endfunction

  // Small values force ties on the minimum
  function automatic logic [PRI_W-1:0] pick_priority();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2, 3: return PRI_W'($urandom_range(0, 7));
      default: return PRI_W'($urandom);
    endcase
  endfunction

  function automatic logic [ACTION_W-1:0] pick_any_action();
    if ($urandom_range(0, 15) == 0)
      return ACTION_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
    return ACTION_W'($urandom_range(ACT_INSERT, ACT_REMOVE));
  endfunction

  function automatic logic [ACTION_W-1:0] pick_action(phase_t kind);
    int roll;
    roll = $urandom_range(0, 15);
    case (kind)
      PH_FILL:   return (roll < 13) ? ACT_INSERT : pick_any_action();
      PH_DRAIN: begin
        if (roll < 11) return ACT_REMOVE;
        if (roll < 13) return ACT_FIND_MIN;
        return pick_any_action();
      end
      PH_UPDATE: begin
        if (roll < 6) return ACT_CHANGE;
        if (roll < 10) return ACT_FIND_MIN;
        if (roll < 13) return ACT_CONTAINS;
        return pick_any_action();
      end
      default:   return pick_any_action();
    endcase
  endfunction

  // Offer one request after a random gap (none in steady mode) and record its expected result
  task automatic send_request(input logic [ACTION_W-1:0] act, input logic [KEY_W-1:0] key,
                              input logic [PRI_W-1:0] pri, input logic typed,
                              input mpqdk_res_t typed_res);
    int         gap;
    mpqdk_res_t predicted;
    gap = steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_chan_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan_if.valid        <= 1'b1;
    in_chan_if.action       <= act;
    in_chan_if.key          <= key;
    in_chan_if.priority_req <= pri;
    @(posedge clk);
    while (!in_chan_if.ready) @(posedge clk);
    predicted = queue_step(act, key, pri);
    expected_q.push_back(typed ? typed_res : predicted);
  endtask

  task automatic report_mismatch(input string what, input mpqdk_res_t want,
                                 input mpqdk_res_t got);
    mismatches++;
    if (mismatches <= SHOW_LIMIT)
      $display({"%0t: %s: expected key=%h found=%0b status=%0d empty=%0b,",
                " got key=%h found=%0b status=%0d empty=%0b"},
               $realtime, what, want.result_key, want.found, want.status, want.is_empty,
               got.result_key, got.found, got.status, got.is_empty);
  endtask

  // Count cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_chan_if.valid && in_chan_if.ready) || (out_chan_if.valid && out_chan_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // Take results with random stalls and check each against the oldest expectation
  initial begin : result_sink
    int         gap;
    mpqdk_res_t want;
    mpqdk_res_t got;
    out_chan_if.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (hold_off_req) begin
        // Long hold-off so the queue backs up into the request channel
        out_chan_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
          out_chan_if.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_chan_if.ready <= 1'b1;
      @(posedge clk);
      while (out_chan_if.valid !== 1'b1) @(posedge clk);
      got.result_key = out_chan_if.result_key;
      got.found      = out_chan_if.found;
      got.status     = status_t'(out_chan_if.status);
      got.is_empty   = out_chan_if.is_empty;
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing expected", '0, got);
      end else begin
        want = expected_q.pop_front();
        if (got.result_key !== want.result_key || got.found !== want.found ||
            got.status !== want.status || got.is_empty !== want.is_empty)
          report_mismatch("result mismatch", want, got);
      end
    end
  end

  initial begin : stimulus
    int                  sent;
    int                  phase_idx;
    int                  len;
    phase_t              kind;
    logic [ACTION_W-1:0] act;
    rst_n                   <= 1'b0;
    in_chan_if.valid        <= 1'b0;
    in_chan_if.action       <= ACT_INSERT;
    in_chan_if.key          <= '0;
    in_chan_if.priority_req <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (DIRECTED_ROWS[i]) begin
      send_request(DIRECTED_ROWS[i].act, DIRECTED_ROWS[i].key, DIRECTED_ROWS[i].pri,
                   DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
    end

    // Random phases; the first one is mostly inserts
    sent      = 0;
    phase_idx = 0;
    while (sent < RANDOM_ITEMS) begin
      kind   = (phase_idx == 0) ? PH_FILL : phase_t'($urandom_range(PH_FILL, PH_UPDATE));
      steady = ($urandom_range(0, 3) == 0);
      if (phase_idx == 2) hold_off_req = 1'b1;
      if (phase_idx % 5 == 4) begin
        // Pause the sender until every result is back
        in_chan_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
      end
      if (kind == PH_FILL || kind == PH_DRAIN) len = CAPACITY + $urandom_range(4, 16);
      else len = $urandom_range(20, 60);
      repeat (len) begin
        act = pick_action(kind);
        send_request(act, pick_key(), pick_priority(), 1'b0, RES_OK);
        sent++;
      end
      phase_idx++;
    end
    in_chan_if.valid <= 1'b0;
    steady = 1'b0;

    // Drain, then allow for a late extra result
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatches += expected_q.size();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
